[design/mesh_adjacency_table_builder_macros.svh]
// Assertion helpers for the table builder design file.
`ifndef MESH_ADJACENCY_TABLE_BUILDER_MACROS_SVH
`define MESH_ADJACENCY_TABLE_BUILDER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mat_pkg.sv]
`default_nettype none
package mat_pkg;

  localparam int MaxVerticesDefault = 1024;
  localparam int MaxDegreeDefault   = 32;
  localparam int IdxW               = 10;
  localparam int CountW             = 11;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_TET   = 2'd1,
    REQ_TRI   = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_PAIR,
    ST_LEN_RD,
    ST_LEN_WT,
    ST_ROW_RD,
    ST_ROW_WT,
    ST_NEXT,
    ST_Q_RD,
    ST_Q_WT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_t;

  typedef struct packed {
    corner_t x;
    corner_t y;
  } pair_t;

  // Corner pair for a pair number: six pairs for a tetrahedron, three for a triangle.
  function automatic pair_t pair_corners(input logic is_tet, input logic [2:0] idx);
    pair_t p;
    p = '{x: CORNER_A, y: CORNER_B};
    case (idx)
      3'd0: p = '{x: CORNER_A, y: CORNER_B};
      3'd1: p = '{x: CORNER_A, y: CORNER_C};
      3'd2: p = is_tet ? '{x: CORNER_A, y: CORNER_D} : '{x: CORNER_B, y: CORNER_C};
      3'd3: p = '{x: CORNER_B, y: CORNER_C};
      3'd4: p = '{x: CORNER_B, y: CORNER_D};
      3'd5: p = '{x: CORNER_C, y: CORNER_D};
      default: p = '{x: CORNER_A, y: CORNER_B};
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[design/mat_ram.sv]
`default_nettype none
module mat_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/mesh_adjacency_table_builder.sv]
// A clear sweeps all list lengths to zero; a query reads the list length and then returns
// each neighbour in turn. An add runs 6 (triangle) or 12 (tetrahedron) inserts, each of
// which reads the owner's list length, scans the sorted row and stores a new value in place,
// rippling the tail up, through the one-read-one-write row RAM.
// Throughput: one transaction at a time; the next is taken once the last result is queued.
// Reset: synchronous; afterwards a sweep zeroes all list lengths and no input is taken until
// it finishes (configuration writes are taken throughout).
`default_nettype none
`include "mesh_adjacency_table_builder_macros.svh"
module mesh_adjacency_table_builder #(
  parameter int MAX_VERTICES = mat_pkg::MaxVerticesDefault,
  parameter int MAX_DEGREE   = mat_pkg::MaxDegreeDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write_en,
  input  wire logic [mat_pkg::CountW-1:0]  cfg_write_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  req_type,
  input  wire logic [mat_pkg::IdxW-1:0]    vertex_a,
  input  wire logic [mat_pkg::IdxW-1:0]    vertex_b,
  input  wire logic [mat_pkg::IdxW-1:0]    vertex_c,
  input  wire logic [mat_pkg::IdxW-1:0]    vertex_d,
  input  wire logic [mat_pkg::IdxW-1:0]    query_vertex,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic [mat_pkg::IdxW-1:0]         neighbour,
  output logic                             has_neighbour,
  output logic                             last
);
  import mat_pkg::*;

  localparam int VA_W  = $clog2(MAX_VERTICES);
  localparam int NA_W  = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int LEN_W = $clog2(MAX_DEGREE + 1);
  localparam int LIM_W = ($clog2(MAX_VERTICES + 1) > CountW) ? $clog2(MAX_VERTICES + 1)
                                                              : CountW;
  localparam int STEP_W = 4;

  state_t state, state_next;

  logic [CountW-1:0] vertex_count;
  logic [LIM_W-1:0]  limit;

  req_t             req, req_next;
  logic [IdxW-1:0]  va, vb, vc, vd;
  logic [STEP_W-1:0] step, step_next;
  logic [VA_W-1:0]  owner, owner_next;
  logic [IdxW-1:0]  value, value_next;
  logic [NA_W-1:0]  base, base_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] pos, pos_next;
  logic [IdxW-1:0]  carry, carry_next;
  logic             ins, ins_next;
  logic             dropped, dropped_next;
  status_t          res_status, res_status_next;
  logic [VA_W-1:0]  clr_ptr, clr_ptr_next;
  logic             clr_req, clr_req_next;

  logic             out_load;
  status_t          load_status;
  logic [IdxW-1:0]  load_nb;
  logic             load_has, load_last;

  logic             len_we;
  logic [VA_W-1:0]  len_waddr;
  logic [LEN_W-1:0] len_wdata, len_rdata;
  logic             row_we;
  logic [NA_W-1:0]  row_waddr, row_raddr, row_addr;
  logic [IdxW-1:0]  row_wdata, row_rdata;

  logic             accept;
  logic             bad_any;
  logic             full;
  logic             row_scan;
  pair_t            pr;
  logic [IdxW-1:0]  cx, cy;

  mat_ram #(.WIDTH(LEN_W), .DEPTH(MAX_VERTICES)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (owner),
    .rdata (len_rdata)
  );

  mat_ram #(.WIDTH(IdxW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  assign limit = (LIM_W'(vertex_count) > LIM_W'(MAX_VERTICES)) ? LIM_W'(MAX_VERTICES)
                                                                : LIM_W'(vertex_count);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (len >= LEN_W'(MAX_DEGREE));
  assign row_addr = base + NA_W'(pos);
  assign row_scan = (state == ST_ROW_RD) || (state == ST_ROW_WT);
  assign bad_any  = (LIM_W'(vertex_a) >= limit) || (LIM_W'(vertex_b) >= limit) ||
                    (LIM_W'(vertex_c) >= limit) ||
                    ((req_type == REQ_TET) && (LIM_W'(vertex_d) >= limit));

  function automatic logic [IdxW-1:0] pick(input corner_t c, input logic [IdxW-1:0] a,
                                           input logic [IdxW-1:0] b,
                                           input logic [IdxW-1:0] cc,
                                           input logic [IdxW-1:0] d);
    logic [IdxW-1:0] r;
    r = a;
    case (c)
      CORNER_A: r = a;
      CORNER_B: r = b;
      CORNER_C: r = cc;
      CORNER_D: r = d;
      default:  r = a;
    endcase
    return r;
  endfunction

  assign pr = pair_corners(req == REQ_TET, step[STEP_W-1:1]);
  assign cx = pick(pr.x, va, vb, vc, vd);
  assign cy = pick(pr.y, va, vb, vc, vd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      vertex_count <= '0;
      clr_ptr      <= '0;
      clr_req      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      clr_ptr   <= clr_ptr_next;
      clr_req   <= clr_req_next;
      out_valid <= out_load || (out_valid && out_stall);
      if (cfg_write_en) begin
        vertex_count <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    step       <= step_next;
    owner      <= owner_next;
    value      <= value_next;
    base       <= base_next;
    len        <= len_next;
    pos        <= pos_next;
    carry      <= carry_next;
    ins        <= ins_next;
    dropped    <= dropped_next;
    res_status <= res_status_next;
    if (accept) begin
      va <= vertex_a;
      vb <= vertex_b;
      vc <= vertex_c;
      vd <= vertex_d;
    end
    if (out_load) begin
      status        <= load_status;
      neighbour     <= load_nb;
      has_neighbour <= load_has;
      last          <= load_last;
    end
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    step_next       = step;
    owner_next      = owner;
    value_next      = value;
    base_next       = base;
    len_next        = len;
    pos_next        = pos;
    carry_next      = carry;
    ins_next        = ins;
    dropped_next    = dropped;
    res_status_next = res_status;
    clr_ptr_next    = clr_ptr;
    clr_req_next    = clr_req;
    out_load        = 1'b0;
    load_status     = STAT_OK;
    load_nb         = '0;
    load_has        = 1'b0;
    load_last       = 1'b1;
    len_we          = 1'b0;
    len_waddr       = owner;
    len_wdata       = len + LEN_W'(1);
    row_we          = 1'b0;
    row_waddr       = row_addr;
    row_wdata       = value;
    row_raddr       = row_addr;

    case (state)
      ST_CLR: begin
        len_we       = 1'b1;
        len_waddr    = clr_ptr;
        len_wdata    = '0;
        clr_ptr_next = clr_ptr + VA_W'(1);
        if (clr_ptr == VA_W'(MAX_VERTICES - 1)) begin
          clr_ptr_next    = '0;
          clr_req_next    = 1'b0;
          res_status_next = STAT_OK;
          state_next      = clr_req ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_next = req_t'(req_type);
          case (req_t'(req_type))
            REQ_CLEAR: begin
              clr_ptr_next = '0;
              clr_req_next = 1'b1;
              state_next   = ST_CLR;
            end
            REQ_QUERY: begin
              if (LIM_W'(query_vertex) >= limit) begin
                res_status_next = STAT_BAD;
                state_next      = ST_DONE;
              end else begin
                owner_next = VA_W'(query_vertex);
                state_next = ST_LEN_RD;
              end
            end
            default: begin
              if (bad_any) begin
                res_status_next = STAT_BAD;
                state_next      = ST_DONE;
              end else begin
                step_next    = '0;
                dropped_next = 1'b0;
                state_next   = ST_PAIR;
              end
            end
          endcase
        end
      end
      ST_PAIR: begin
        // even step: x gets y, odd step: y gets x
        owner_next = step[0] ? VA_W'(cy) : VA_W'(cx);
        value_next = step[0] ? cx : cy;
        state_next = ST_LEN_RD;
      end
      ST_LEN_RD: begin
        base_next  = NA_W'(owner) * NA_W'(MAX_DEGREE);
        state_next = ST_LEN_WT;
      end
      ST_LEN_WT: begin
        len_next = len_rdata;
        pos_next = '0;
        ins_next = 1'b0;
        if (req == REQ_QUERY) begin
          if (len_rdata == '0) begin
            res_status_next = STAT_OK;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_Q_RD;
          end
        end else begin
          state_next = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        if (pos == len) begin
          if (ins) begin
            row_we     = 1'b1;
            row_wdata  = carry;
            len_we     = 1'b1;
          end else if (full) begin
            dropped_next = 1'b1;
          end else begin
            row_we = 1'b1;
            len_we = 1'b1;
          end
          state_next = ST_NEXT;
        end else begin
          state_next = ST_ROW_WT;
        end
      end
      ST_ROW_WT: begin
        if (ins) begin
          // ripple the tail up by one slot
          row_we     = 1'b1;
          row_wdata  = carry;
          carry_next = row_rdata;
          pos_next   = pos + LEN_W'(1);
          state_next = ST_ROW_RD;
        end else if (row_rdata < value) begin
          pos_next   = pos + LEN_W'(1);
          state_next = ST_ROW_RD;
        end else if (row_rdata == value) begin
          state_next = ST_NEXT;
        end else if (full) begin
          dropped_next = 1'b1;
          state_next   = ST_NEXT;
        end else begin
          row_we     = 1'b1;
          carry_next = row_rdata;
          ins_next   = 1'b1;
          pos_next   = pos + LEN_W'(1);
          state_next = ST_ROW_RD;
        end
      end
      ST_NEXT: begin
        if (step == ((req == REQ_TET) ? STEP_W'(11) : STEP_W'(5))) begin
          res_status_next = dropped ? STAT_FULL : STAT_OK;
          state_next      = ST_DONE;
        end else begin
          step_next  = step + STEP_W'(1);
          state_next = ST_PAIR;
        end
      end
      ST_Q_RD: begin
        if (!out_valid) begin
          state_next = ST_Q_WT;
        end
      end
      ST_Q_WT: begin
        out_load    = 1'b1;
        load_status = STAT_OK;
        load_nb     = row_rdata;
        load_has    = 1'b1;
        load_last   = ((pos + LEN_W'(1)) == len);
        pos_next    = pos + LEN_W'(1);
        state_next  = load_last ? ST_IDLE : ST_Q_RD;
      end
      ST_DONE: begin
        if (!out_valid) begin
          out_load    = 1'b1;
          load_status = res_status;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MAT_ASSERT_NOW(a_no_overwrite, out_load, !out_valid, "result register overwritten")
  `MAT_ASSERT_NOW(a_pos_in_list, row_scan, pos <= len, "row position past list length")
  `MAT_ASSERT_NOW(a_no_overfill, row_we, len < LEN_W'(MAX_DEGREE), "row write into a full list")
  `MAT_ASSERT_NEXT(a_query_row, state == ST_Q_RD && !out_valid, state == ST_Q_WT, "query load missed")

endmodule
`default_nettype wire

[tb/mesh_adjacency_table_builder_checker.sv]
`default_nettype none
module mesh_adjacency_table_builder_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write_en,
  input  wire logic [mat_pkg::CountW-1:0] cfg_write_data,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [1:0]                 req_type,
  input  wire logic [mat_pkg::IdxW-1:0]   vertex_a,
  input  wire logic [mat_pkg::IdxW-1:0]   vertex_b,
  input  wire logic [mat_pkg::IdxW-1:0]   vertex_c,
  input  wire logic [mat_pkg::IdxW-1:0]   vertex_d,
  input  wire logic [mat_pkg::IdxW-1:0]   query_vertex,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [1:0]                 status,
  input  wire logic [mat_pkg::IdxW-1:0]   neighbour,
  input  wire logic                       has_neighbour,
  input  wire logic                       last,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mat_pkg::*;

  localparam int NumVert = MaxVerticesDefault;
  localparam int Degree  = MaxDegreeDefault;

  typedef struct {
    status_t        st;
    logic [IdxW-1:0] nb;
    logic           has;
    logic           lst;
  } adj_result_t;

  adj_result_t     result_q[$];
  int              adj_len[NumVert];
  logic [IdxW-1:0] adj_row[NumVert][Degree];
  logic [CountW-1:0] vcount;

  function automatic int vertex_limit();
    return (vcount > NumVert) ? NumVert : int'(vcount);
  endfunction

  // Sorted unique insert; returns 0 when the neighbour is dropped.
  function automatic bit insert_neighbour(int owner, logic [IdxW-1:0] value);
    int len;
    int pos;
    len = adj_len[owner];
    pos = 0;
    while (pos < len && adj_row[owner][pos] < value) pos++;
    if (pos < len && adj_row[owner][pos] == value) return 1'b1;
    if (len >= Degree) return 1'b0;
    for (int k = len; k > pos; k--) adj_row[owner][k] = adj_row[owner][k-1];
    adj_row[owner][pos] = value;
    adj_len[owner] = len + 1;
    return 1'b1;
  endfunction

  function automatic void push_result(status_t st, logic [IdxW-1:0] nb, logic has,
                                      logic lst);
    adj_result_t r;
    r.st = st;
    r.nb = nb;
    r.has = has;
    r.lst = lst;
    result_q.push_back(r);
  endfunction

  function automatic void predict_request(req_t req, logic [IdxW-1:0] corner[4],
                                          logic [IdxW-1:0] qv);
    int lim;
    int n;
    bit ok;
    bit dropped;
    lim = vertex_limit();
    case (req)
      REQ_CLEAR: begin
        foreach (adj_len[i]) adj_len[i] = 0;
        push_result(STAT_OK, '0, 1'b0, 1'b1);
      end
      REQ_QUERY: begin
        if (qv >= lim) push_result(STAT_BAD, '0, 1'b0, 1'b1);
        else if (adj_len[qv] == 0) push_result(STAT_OK, '0, 1'b0, 1'b1);
        else begin
          for (int i = 0; i < adj_len[qv]; i++)
            push_result(STAT_OK, adj_row[qv][i], 1'b1, (i + 1 == adj_len[qv]));
        end
      end
      default: begin
        n = (req == REQ_TET) ? 4 : 3;
        ok = 1'b1;
        for (int i = 0; i < n; i++) if (corner[i] >= lim) ok = 1'b0;
        if (!ok) push_result(STAT_BAD, '0, 1'b0, 1'b1);
        else begin
          dropped = 1'b0;
          for (int x = 0; x < n; x++)
            for (int y = x + 1; y < n; y++) begin
              if (!insert_neighbour(corner[x], corner[y])) dropped = 1'b1;
              if (!insert_neighbour(corner[y], corner[x])) dropped = 1'b1;
            end
          push_result(dropped ? STAT_FULL : STAT_OK, '0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    logic [IdxW-1:0] corner[4];
    adj_result_t want;
    if (rst) begin
      result_q.delete();
      foreach (adj_len[i]) adj_len[i] = 0;
      vcount = '0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_write_en) vcount = cfg_write_data;
      if (in_valid && !in_stall) begin
        corner[0] = vertex_a;
        corner[1] = vertex_b;
        corner[2] = vertex_c;
        corner[3] = vertex_d;
        predict_request(req_t'(req_type), corner, query_vertex);
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with no transaction pending");
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (status != want.st || neighbour != want.nb || has_neighbour != want.has ||
              last != want.lst) begin
            fail_count <= fail_count + 1;
            if (status != want.st)
              $error("status expected %0d actual %0d", want.st, status);
            if (neighbour != want.nb)
              $error("neighbour expected %0d actual %0d", want.nb, neighbour);
            if (has_neighbour != want.has)
              $error("has_neighbour expected %0d actual %0d", want.has, has_neighbour);
            if (last != want.lst)
              $error("last expected %0d actual %0d", want.lst, last);
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule
`default_nettype wire

[tb/mesh_adjacency_table_builder_tb.sv]
`default_nettype none
module mesh_adjacency_table_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mat_pkg::*;

  localparam int HoldCycles = 400;
  localparam int IdleLimit  = 8000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CountW-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [IdxW-1:0] vertex_a = '0, vertex_b = '0, vertex_c = '0, vertex_d = '0;
  logic [IdxW-1:0] query_vertex = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [IdxW-1:0] neighbour;
  logic has_neighbour;
  logic last;
  int fail_count;
  int pending;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int pick_base = 0;
  int pick_span = 16;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mesh_adjacency_table_builder uut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .vertex_a(vertex_a), .vertex_b(vertex_b),
    .vertex_c(vertex_c), .vertex_d(vertex_d), .query_vertex(query_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .neighbour(neighbour), .has_neighbour(has_neighbour), .last(last)
  );

  mesh_adjacency_table_builder_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .vertex_a(vertex_a), .vertex_b(vertex_b),
    .vertex_c(vertex_c), .vertex_d(vertex_d), .query_vertex(query_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .neighbour(neighbour), .has_neighbour(has_neighbour), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_request(req_t req, int a, int b, int c, int d, int q);
    in_valid <= 1'b1;
    req_type <= req;
    vertex_a <= IdxW'(a);
    vertex_b <= IdxW'(b);
    vertex_c <= IdxW'(c);
    vertex_d <= IdxW'(d);
    query_vertex <= IdxW'(q);
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(int value);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_write_data <= CountW'(value);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_vertex();
    if ($urandom_range(0, 99) < 8) return $urandom_range(0, 1023);
    return (pick_base + $urandom_range(0, pick_span - 1)) % 1024;
  endfunction

  task automatic random_requests(int count);
    int r;
    req_t req;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) req = REQ_CLEAR;
      else if (r < 40) req = REQ_TET;
      else if (r < 68) req = REQ_TRI;
      else req = REQ_QUERY;
      send_request(req, pick_vertex(), pick_vertex(), pick_vertex(), pick_vertex(),
                   (req == REQ_QUERY) ? pick_vertex() : $urandom_range(0, 1023));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Count zero rejects everything except clear.
    send_request(REQ_QUERY, 0, 0, 0, 0, 0);
    send_request(REQ_TRI, 0, 0, 0, 0, 0);
    send_request(REQ_CLEAR, 1023, 1023, 1023, 1023, 1023);
    write_vertex_count(1024);
    send_request(REQ_QUERY, 0, 0, 0, 0, 5);
    send_request(REQ_TRI, 5, 1023, 0, 0, 0);
    send_request(REQ_TET, 5, 6, 7, 8, 0);
    send_request(REQ_TET, 5, 6, 7, 8, 0);
    send_request(REQ_TRI, 9, 9, 5, 0, 0);
    send_request(REQ_QUERY, 0, 0, 0, 0, 5);
    send_request(REQ_QUERY, 0, 0, 0, 0, 9);
    send_request(REQ_QUERY, 0, 0, 0, 0, 1023);
    send_request(REQ_TET, 1023, 0, 682, 341, 0);
    send_request(REQ_QUERY, 0, 0, 0, 0, 682);
    write_vertex_count(100);
    send_request(REQ_TRI, 99, 100, 1, 0, 0);
    send_request(REQ_TET, 1, 2, 3, 1023, 0);
    send_request(REQ_QUERY, 0, 0, 0, 0, 100);
    send_request(REQ_QUERY, 0, 0, 0, 0, 99);
    send_request(REQ_CLEAR, 0, 0, 0, 0, 0);
    send_request(REQ_QUERY, 0, 0, 0, 0, 5);

    // Wide count, clustered corners.
    write_vertex_count(1024);
    pick_base = $urandom_range(0, 1023);
    pick_span = 24;
    random_requests(60);
    pick_base = $urandom_range(0, 1023);
    random_requests(60);

    // Dense mesh: lists fill up and neighbours get dropped.
    write_vertex_count(40);
    pick_base = 0;
    pick_span = 40;
    random_requests(60);
    hold_req = 1'b1;
    random_requests(40);
    drain_results();
    random_requests(50);

    // Shrink the count; entries above it stay in lists.
    write_vertex_count(20);
    random_requests(60);

    write_vertex_count(1);
    pick_span = 4;
    random_requests(20);

    // Out-of-range count register value, no idling to the end.
    write_vertex_count(2047);
    quiet = 1'b1;
    pick_base = $urandom_range(0, 1023);
    pick_span = 32;
    random_requests(100);

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+design
design/mat_pkg.sv
design/mat_ram.sv
design/mesh_adjacency_table_builder.sv
tb/mesh_adjacency_table_builder_checker.sv
tb/mesh_adjacency_table_builder_tb.sv
